>>> hdl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define UPSC_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UPSC_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/upsc_pkg.sv
// shared constants, types and hash helpers of the unique pair sum counter
package upsc_pkg;

    localparam int SEEN_SLOTS = 1024;
    localparam int PAIR_SLOTS = 1024;
    localparam int SEEN_IW    = $clog2(SEEN_SLOTS);
    localparam int PAIR_IW    = $clog2(PAIR_SLOTS);
    localparam int MAX_SLOTS  = (SEEN_SLOTS > PAIR_SLOTS) ? SEEN_SLOTS : PAIR_SLOTS;
    localparam int CLR_W      = $clog2(MAX_SLOTS);

    localparam logic [10:0] COUNT_MAX = 11'd2047;
    localparam logic [31:0] SEEN_MULT = 32'd2654435761;
    localparam logic [63:0] MIX_GOLD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LHASH,
        OP_SNEXT,
        OP_MKEY,
        OP_MADD,
        OP_XS30,
        OP_XS27,
        OP_XS31,
        OP_P0A,
        OP_P1A,
        OP_P2A,
        OP_P0B,
        OP_P1B,
        OP_P2B,
        OP_PNEXT,
        OP_PWRITE,
        OP_PFULL,
        OP_IHASH,
        OP_SWRITE,
        OP_SFULL,
        OP_LOAD,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic rdy;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic sv;
        logic s_eq_y;
        logic s_eq_x;
        logic s_end;
        logic pv;
        logic p_eq;
        logic p_end;
        logic out_busy;
        logic clr_end;
    } t_stat;

    function automatic logic [SEEN_IW-1:0] seen_home(input logic [31:0] k);
        logic [SEEN_IW-1:0] p;
        p = k[SEEN_IW-1:0] * SEEN_MULT[SEEN_IW-1:0];
        return p;
    endfunction

endpackage

>>> hdl/upsc_ctrl.sv
// sequencer that walks lookup, pair hash, pair insert, seen insert and clearing
module upsc_ctrl
    import upsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LHASH, S_LRD, S_LCMP, S_MKEY, S_MADD, S_X30,
        S_P0A, S_P1A, S_P2A, S_X27, S_P0B, S_P1B, S_P2B, S_X31,
        S_PRD, S_PCMP, S_IHASH, S_IRD, S_ICMP, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        o_cmd.rdy = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.rdy = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_LHASH;
                end
            end
            S_LHASH: begin
                o_cmd.op = OP_LHASH;
                n_state  = S_LRD;
            end
            S_LRD: n_state = S_LCMP;
            S_LCMP: begin
                if (!i_stat.sv) begin
                    n_state = S_IHASH;
                end else if (i_stat.s_eq_y) begin
                    n_state = S_MKEY;
                end else if (i_stat.s_end) begin
                    n_state = S_IHASH;
                end else begin
                    o_cmd.op = OP_SNEXT;
                    n_state  = S_LRD;
                end
            end
            S_MKEY: begin o_cmd.op = OP_MKEY; n_state = S_MADD; end
            S_MADD: begin o_cmd.op = OP_MADD; n_state = S_X30;  end
            S_X30:  begin o_cmd.op = OP_XS30; n_state = S_P0A;  end
            S_P0A:  begin o_cmd.op = OP_P0A;  n_state = S_P1A;  end
            S_P1A:  begin o_cmd.op = OP_P1A;  n_state = S_P2A;  end
            S_P2A:  begin o_cmd.op = OP_P2A;  n_state = S_X27;  end
            S_X27:  begin o_cmd.op = OP_XS27; n_state = S_P0B;  end
            S_P0B:  begin o_cmd.op = OP_P0B;  n_state = S_P1B;  end
            S_P1B:  begin o_cmd.op = OP_P1B;  n_state = S_P2B;  end
            S_P2B:  begin o_cmd.op = OP_P2B;  n_state = S_X31;  end
            S_X31:  begin o_cmd.op = OP_XS31; n_state = S_PRD;  end
            S_PRD:  n_state = S_PCMP;
            S_PCMP: begin
                if (!i_stat.pv) begin
                    o_cmd.op = OP_PWRITE;
                    n_state  = S_IHASH;
                end else if (i_stat.p_eq) begin
                    n_state = S_IHASH;
                end else if (i_stat.p_end) begin
                    o_cmd.op = OP_PFULL;
                    n_state  = S_IHASH;
                end else begin
                    o_cmd.op = OP_PNEXT;
                    n_state  = S_PRD;
                end
            end
            S_IHASH: begin
                o_cmd.op = OP_IHASH;
                n_state  = S_IRD;
            end
            S_IRD: n_state = S_ICMP;
            S_ICMP: begin
                if (!i_stat.sv || i_stat.s_eq_x) begin
                    o_cmd.op = OP_SWRITE;
                    n_state  = S_DONE;
                end else if (i_stat.s_end) begin
                    o_cmd.op = OP_SFULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SNEXT;
                    n_state  = S_IRD;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_stat.last ? S_CLR : S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/upsc_dp.sv
// datapath: hash tables, splitmix multiplier, counter and result register
module upsc_dp
    import upsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic [31:0] i_value,
    input  logic        i_last,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [10:0] o_pair_count,
    output logic        o_new_pair,
    output logic        o_table_full,
    output logic        o_is_last
);

`include "assert_macros.svh"

    logic [31:0] seen_keys  [SEEN_SLOTS];
    logic        seen_valid [SEEN_SLOTS];
    logic [63:0] pair_keys  [PAIR_SLOTS];
    logic        pair_valid [PAIR_SLOTS];

    logic [31:0]        r_target;
    logic [31:0]        r_x, r_y;
    logic               r_last, r_fresh, r_full;
    logic [63:0]        r_key, r_h, r_acc;
    logic [SEEN_IW-1:0] r_sidx;
    logic [PAIR_IW-1:0] r_pidx;
    logic [CLR_W-1:0]   r_probe, r_clr;
    logic [10:0]        r_count;
    logic [31:0]        r_sk_q;
    logic               r_sv_q;
    logic [63:0]        r_pk_q;
    logic               r_pv_q;
    logic               r_out_valid;
    logic [10:0]        r_o_cnt;
    logic               r_o_fresh, r_o_full, r_o_last;

    logic [31:0]        w_mul_a, w_mul_b;
    logic [63:0]        w_prod, w_c, w_fin;
    logic               w_x_lt;
    logic               w_sv_we, w_sv_d, w_pv_we, w_pv_d;
    logic [SEEN_IW-1:0] w_sv_addr;
    logic [PAIR_IW-1:0] w_pv_addr;

    assign w_c    = (i_cmd.op == OP_P0B || i_cmd.op == OP_P1B || i_cmd.op == OP_P2B)
                    ? MIX_C2 : MIX_C1;
    assign w_fin  = r_h ^ (r_h >> 31);
    assign w_x_lt = $signed(r_x) < $signed(r_y);

    always_comb begin
        w_mul_a = r_h[31:0];
        w_mul_b = w_c[31:0];
        case (i_cmd.op)
            OP_P1A, OP_P1B: w_mul_b = w_c[63:32];
            OP_P2A, OP_P2B: w_mul_a = r_h[63:32];
            default: w_mul_a = r_h[31:0];
        endcase
    end

    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    // seen table
    assign w_sv_we   = (i_cmd.op == OP_SWRITE) || (i_cmd.op == OP_CLEAR);
    assign w_sv_d    = (i_cmd.op != OP_CLEAR);
    assign w_sv_addr = (i_cmd.op == OP_CLEAR) ? r_clr[SEEN_IW-1:0] : r_sidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SWRITE) begin
            seen_keys[r_sidx] <= r_x;
        end
        r_sk_q <= seen_keys[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_sv_we) begin
            seen_valid[w_sv_addr] <= w_sv_d;
        end
        r_sv_q <= seen_valid[r_sidx];
    end

    // pair table
    assign w_pv_we   = (i_cmd.op == OP_PWRITE) || (i_cmd.op == OP_CLEAR);
    assign w_pv_d    = (i_cmd.op != OP_CLEAR);
    assign w_pv_addr = (i_cmd.op == OP_CLEAR) ? r_clr[PAIR_IW-1:0] : r_pidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PWRITE) begin
            pair_keys[r_pidx] <= r_key;
        end
        r_pk_q <= pair_keys[r_pidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_pv_we) begin
            pair_valid[w_pv_addr] <= w_pv_d;
        end
        r_pv_q <= pair_valid[r_pidx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 32'd0;
            r_count     <= 11'd0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_target <= i_cfg_wr_data;
            if (i_cmd.op == OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_PWRITE: begin
                    if (r_count != COUNT_MAX) r_count <= r_count + 11'd1;
                end
                OP_LOAD: begin
                    if (r_last) r_count <= 11'd0;
                end
                OP_CLEAR: r_clr <= r_clr + 1'b1;
                default: r_clr <= r_clr;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_x     <= i_value;
                r_y     <= r_target - i_value;
                r_last  <= i_last;
                r_fresh <= 1'b0;
                r_full  <= 1'b0;
            end
            OP_LHASH: begin
                r_sidx  <= seen_home(r_y);
                r_probe <= '0;
            end
            OP_IHASH: begin
                r_sidx  <= seen_home(r_x);
                r_probe <= '0;
            end
            OP_SNEXT: begin
                r_sidx  <= r_sidx + 1'b1;
                r_probe <= r_probe + 1'b1;
            end
            OP_MKEY:  r_key <= w_x_lt ? {r_x, r_y} : {r_y, r_x};
            OP_MADD:  r_h   <= r_key + MIX_GOLD;
            OP_XS30:  r_h   <= r_h ^ (r_h >> 30);
            OP_XS27:  r_h   <= r_h ^ (r_h >> 27);
            OP_P0A, OP_P0B: r_acc <= w_prod;
            OP_P1A, OP_P1B: r_acc <= r_acc + {w_prod[31:0], 32'd0};
            OP_P2A, OP_P2B: r_h   <= r_acc + {w_prod[31:0], 32'd0};
            OP_XS31: begin
                r_pidx  <= w_fin[PAIR_IW-1:0];
                r_probe <= '0;
            end
            OP_PNEXT: begin
                r_pidx  <= r_pidx + 1'b1;
                r_probe <= r_probe + 1'b1;
            end
            OP_PWRITE: r_fresh <= 1'b1;
            OP_PFULL:  r_full  <= 1'b1;
            OP_SFULL:  r_full  <= 1'b1;
            OP_LOAD: begin
                r_o_cnt   <= r_count;
                r_o_fresh <= r_fresh;
                r_o_full  <= r_full;
                r_o_last  <= r_last;
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.last     = r_last;
    assign o_stat.sv       = r_sv_q;
    assign o_stat.s_eq_y   = (r_sk_q == r_y);
    assign o_stat.s_eq_x   = (r_sk_q == r_x);
    assign o_stat.s_end    = (r_probe == CLR_W'(SEEN_SLOTS - 1));
    assign o_stat.pv       = r_pv_q;
    assign o_stat.p_eq     = (r_pk_q == r_key);
    assign o_stat.p_end    = (r_probe == CLR_W'(PAIR_SLOTS - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_stat.clr_end  = (r_clr == CLR_W'(MAX_SLOTS - 1));

    assign o_out_valid  = r_out_valid;
    assign o_pair_count = r_o_cnt;
    assign o_new_pair   = r_o_fresh;
    assign o_table_full = r_o_full;
    assign o_is_last    = r_o_last;

    `UPSC_ASSERT_IMP(a_pwrite_free, i_cmd.op == OP_PWRITE, !r_pv_q, "pair write over used slot")
    `UPSC_ASSERT_IMP(a_fresh_count, r_out_valid && r_o_fresh, r_o_cnt != 11'd0, "new pair with zero count")
    `UPSC_ASSERT_IMP(a_load_free, i_cmd.op == OP_LOAD, !r_out_valid || i_out_ready, "result overwritten")

endmodule

>>> hdl/unique_pair_sum_counter.sv
// top level of the unique pair sum counter
// Counts distinct value pairs summing to target_sum over a list of signed 32-bit values,
// one result per request. After reset, and after each request with tlast set, a clearing
// pass over every slot of the larger table runs before the next request is taken. A
// request looks up target_sum minus the value in the seen table, probing slot by slot; on
// a lookup hit it forms the splitmix hash on a shared 32x32 multiplier and probes the pair
// table. In all cases it then inserts the value into the seen table if a slot is free.
// Both tables are memories with registered reads, and each probed slot takes a read state
// and a compare state. A finished result waits in the output register while the next request is taken.
module unique_pair_sum_counter
    import upsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,   // target_sum
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [10:0] pair_count, [11] new_pair, [12] table_full
    output logic        m_axis_tlast
);

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [10:0] w_cnt;
    logic        w_fresh, w_full;

    upsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    upsc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_value       (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pair_count  (w_cnt),
        .o_new_pair    (w_fresh),
        .o_table_full  (w_full),
        .o_is_last     (m_axis_tlast)
    );

    assign s_axis_tready = w_cmd.rdy;
    assign m_axis_tdata  = {3'd0, w_full, w_fresh, w_cnt};

endmodule
